// ===== rtl/core/rsti_pkg.sv =====
package rsti_pkg;

   localparam int CHAR_BITS = 8;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;

   // Register indexes, taken from paddr[4:3] (registers sit on 8-byte strides)
   localparam logic [1:0] REG_BASE_LEN      = 2'd0;
   localparam logic [1:0] REG_ALPHABET_LOW  = 2'd1;
   localparam logic [1:0] REG_ALPHABET_HIGH = 2'd2;

   localparam int BASE_LEN_BITS = 5;
   localparam logic [BASE_LEN_BITS-1:0] BASE_LEN_RESET = 5'd10;
   localparam logic [BASE_LEN_BITS-1:0] MIN_BASE       = 5'd2;
   // "01234567" and "89", symbol 0 in the lowest byte
   localparam logic [63:0] ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] ALPHABET_HIGH_RESET = 64'h0000_0000_0000_3938;

   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;

endpackage

// ===== rtl/core/rsti_digit_match.sv =====
module rsti_digit_match
   import rsti_pkg::*;
#(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic [CHAR_BITS-1:0]               ch,
   input  logic [MAX_SYMBOLS*CHAR_BITS-1:0]   symbols,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0]   base,
   output logic                               hit,
   output logic [$clog2(MAX_SYMBOLS)-1:0]     index
);

   localparam int BASE_BITS  = $clog2(MAX_SYMBOLS + 1);
   localparam int INDEX_BITS = $clog2(MAX_SYMBOLS);

   logic [MAX_SYMBOLS-1:0] match;

   // One comparator per symbol slot; slots at or above the base never match
   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         match[k] = (BASE_BITS'(k) < base) && (ch != CH_NUL) &&
                    (symbols[k*CHAR_BITS +: CHAR_BITS] == ch);
      end
   end

   // Lowest matching slot wins when the alphabet repeats a symbol
   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit   = 1'b1;
            index = INDEX_BITS'(k);
         end
      end
   end

endmodule

// ===== rtl/core/radix_string_to_integer_core.sv =====
// Result: the parsed value is registered into the output slot, or into the spare slot while rsp
//   is stalled, on the transfer of the character marked last; characters not marked last give no result.
// Throughput: one character per cycle (combinational compare and multiply-add); a second
//   result slot absorbs rsp stalls, and input stalls only while both slots are full.
// Reset (synchronous, active high): parser back to leading whitespace, sign positive,
//   accumulator zero, no result pending; base 10 with alphabet "0123456789".
module radix_string_to_integer_core
   import rsti_pkg::*;
#(
   parameter int MAX_SYMBOLS = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,

   // Character stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [CHAR_BITS-1:0]               req_tdata,   // [7:0] ch
   input  logic                               req_tlast,   // last character of the string

   // Parsed values
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]    rsp_tdata,   // [VALUE_BITS-1:0] value, zero pad

   // Register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]           csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]           csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]           csr_prdata,
   output logic                               csr_pready
);

   localparam int BASE_BITS  = $clog2(MAX_SYMBOLS + 1);
   localparam int INDEX_BITS = $clog2(MAX_SYMBOLS);
   localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGIT,
      PH_DONE
   } phase_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [BASE_LEN_BITS-1:0] base_len_ff;
   logic [63:0]              alphabet_low_ff;
   logic [63:0]              alphabet_high_ff;
   logic                     csr_write;
   logic [1:0]               csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff      <= BASE_LEN_RESET;
         alphabet_low_ff  <= ALPHABET_LOW_RESET;
         alphabet_high_ff <= ALPHABET_HIGH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_BASE_LEN:      base_len_ff      <= csr_pwdata[BASE_LEN_BITS-1:0];
            REG_ALPHABET_LOW:  alphabet_low_ff  <= csr_pwdata;
            REG_ALPHABET_HIGH: alphabet_high_ff <= csr_pwdata;
            default: ;  // hole in the map: drop the write
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BASE_LEN:      csr_prdata = CSR_DATA_BITS'(base_len_ff);
         REG_ALPHABET_LOW:  csr_prdata = alphabet_low_ff;
         REG_ALPHABET_HIGH: csr_prdata = alphabet_high_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // Clamp the programmed base into [2, MAX_SYMBOLS]
   logic [BASE_BITS-1:0] base_eff;

   always_comb begin
      if (base_len_ff < MIN_BASE) begin
         base_eff = BASE_BITS'(MIN_BASE);
      end else if (base_len_ff > BASE_LEN_BITS'(MAX_SYMBOLS)) begin
         base_eff = BASE_BITS'(MAX_SYMBOLS);
      end else begin
         base_eff = BASE_BITS'(base_len_ff);
      end
   end

   // ------------------------------------------------------------------
   // Digit lookup
   // ------------------------------------------------------------------
   logic [127:0]            alphabet_all;
   logic                    digit_hit;
   logic [INDEX_BITS-1:0]   digit_index;

   assign alphabet_all = {alphabet_high_ff, alphabet_low_ff};

   rsti_digit_match #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_digit_match (
      .ch      (req_tdata),
      .symbols (alphabet_all[MAX_SYMBOLS*CHAR_BITS-1:0]),
      .base    (base_eff),
      .hit     (digit_hit),
      .index   (digit_index)
   );

   // ------------------------------------------------------------------
   // Parse state update
   // ------------------------------------------------------------------
   phase_type               phase_ff,    phase_in;
   logic                    negative_ff, negative_in;
   logic [VALUE_BITS-1:0]   acc_ff,      acc_in;
   logic [VALUE_BITS-1:0]   acc_step;
   logic [VALUE_BITS-1:0]   value_ff,    value_in;
   logic [VALUE_BITS-1:0]   skid_value_ff;
   logic                    rsp_valid_ff;
   logic                    skid_valid_ff;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    load_result;
   logic                    out_hold;

   // A new character may enter while the spare result slot is free
   assign req_tready  = ~skid_valid_ff;
   assign req_xfer    = req_tvalid & req_tready;
   assign rsp_xfer    = rsp_valid_ff & rsp_tready;
   assign load_result = req_xfer & req_tlast;
   // Output slot keeps its value this cycle: park a new value in the spare slot
   assign out_hold    = rsp_valid_ff & ~rsp_tready;

   // Multiply-add wraps at VALUE_BITS; the multiplicand is at most MAX_SYMBOLS
   assign acc_step = (acc_ff * VALUE_BITS'(base_eff)) + VALUE_BITS'(digit_index);

   // Phases fall through in one character: whitespace -> sign -> digit -> done
   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;

      if (phase_in == PH_SPACE) begin
         if (!(req_tdata inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE})) begin
            phase_in = PH_SIGN;
         end
      end
      if (phase_in == PH_SIGN) begin
         if (req_tdata == CH_MINUS) begin
            negative_in = ~negative_ff;
         end else if (req_tdata != CH_PLUS) begin
            phase_in = PH_DIGIT;
         end
      end
      if (phase_in == PH_DIGIT) begin
         if (digit_hit) begin
            acc_in = acc_step;
         end else begin
            phase_in = PH_DONE;
         end
      end

      value_in = negative_in ? (~acc_in + VALUE_BITS'(1)) : acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SPACE;
         negative_ff   <= 1'b0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            if (req_tlast) begin
               // end of string: restart the parser
               phase_ff    <= PH_SPACE;
               negative_ff <= 1'b0;
               acc_ff      <= '0;
            end else begin
               phase_ff    <= phase_in;
               negative_ff <= negative_in;
               acc_ff      <= acc_in;
            end
         end

         if (load_result) begin
            // spare slot is empty here, since input is held while it is full
            if (out_hold) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (rsp_xfer) begin
            // advance the parked value, if any, into the output slot
            rsp_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: hold each value until its transfer on rsp
   always_ff @(posedge clock) begin
      if (load_result && out_hold) begin
         skid_value_ff <= value_in;
      end else if (load_result) begin
         value_ff <= value_in;
      end else if (rsp_xfer && skid_valid_ff) begin
         value_ff <= skid_value_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(value_ff);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> rsp_tvalid)
      else $error("no result after the last character of a string");

   a_last_restarts_parse: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> (phase_ff == PH_SPACE && !negative_ff && acc_ff == '0))
      else $error("parser not restarted after the end of a string");

   a_done_is_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !(req_xfer && req_tlast))
         |=> (phase_ff == PH_DONE && $stable(acc_ff) && $stable(negative_ff)))
      else $error("parse state moved after the first non-digit");

   a_spare_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("spare result slot full while the output slot is empty");

endmodule

// ===== tb/radix_string_to_integer_core_test.sv =====
module radix_string_to_integer_core_test;
   import rsti_pkg::*;

   localparam int MAX_SYMBOLS  = 16;
   localparam int ITEM_TARGET  = 1200;
   localparam int NUM_PHASES   = 10;
   localparam int MAX_REPORTS  = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef enum logic [1:0] {
      SCAN_SPACE,
      SCAN_SIGN,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_state_e;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_LONG
   } ready_mode_e;

   // Parser mirror plus the queue of parsed values still owed by the block.
   class parse_scoreboard;
      logic [BASE_LEN_BITS-1:0] base_len;
      logic [63:0]              alpha_low;
      logic [63:0]              alpha_high;
      scan_state_e              state;
      bit                       negative;
      logic [31:0]              acc;
      logic [31:0]              value_q[$];
      int                       errors;
      int                       values_seen;
      int                       strings_seen;
      int                       chars_seen;

      function new();
         base_len     = BASE_LEN_RESET;
         alpha_low    = ALPHABET_LOW_RESET;
         alpha_high   = ALPHABET_HIGH_RESET;
         errors       = 0;
         values_seen  = 0;
         strings_seen = 0;
         chars_seen   = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         state    = SCAN_SPACE;
         negative = 1'b0;
         acc      = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] data);
         case (idx)
            REG_BASE_LEN:      base_len = data[BASE_LEN_BITS-1:0];
            REG_ALPHABET_LOW:  alpha_low = data;
            REG_ALPHABET_HIGH: alpha_high = data;
            default: ;
         endcase
      endfunction

      function int radix();
         int b;
         b = base_len;
         if (b < MIN_BASE) b = MIN_BASE;
         if (b > MAX_SYMBOLS) b = MAX_SYMBOLS;
         return b;
      endfunction

      function logic [7:0] symbol(int k);
         if (k < 8) return alpha_low[k*8 +: 8];
         else return alpha_high[(k-8)*8 +: 8];
      endfunction

      function int digit_of(logic [7:0] c);
         if (c == CH_NUL) return -1;
         for (int k = 0; k < radix(); k++)
            if (symbol(k) == c) return k;
         return -1;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
                c == CH_CR || c == CH_SPACE;
      endfunction

      function void note_char(logic [7:0] c, bit is_last);
         int          d;
         logic [31:0] v;
         chars_seen++;
         if (state == SCAN_SPACE && !is_space(c)) state = SCAN_SIGN;
         if (state == SCAN_SIGN) begin
            if (c == CH_MINUS) negative = !negative;
            else if (c != CH_PLUS) state = SCAN_DIGITS;
         end
         if (state == SCAN_DIGITS) begin
            d = digit_of(c);
            if (d >= 0) acc = acc * 32'(radix()) + 32'(d);
            else state = SCAN_DONE;
         end
         if (is_last) begin
            v = negative ? -acc : acc;
            value_q.push_back(v);
            strings_seen++;
            clear_scan();
         end
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch: %s expected %0d (%h) got %0d (%h)", what,
                     $signed(want), want, $signed(got), got);
      endfunction

      function void check_value(logic [31:0] got);
         logic [31:0] want;
         values_seen++;
         if (value_q.size() == 0) begin
            report("value with none owed,", 32'h0, got);
         end else begin
            want = value_q.pop_front();
            if (want !== got) report("value", want, got);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   parse_scoreboard sb;
   ready_mode_e     ready_mode;
   bit              gaps_on;
   int              burst_left;
   int              stall_left;
   int              ready_tick;
   int              cycle_count;
   int              items_sent;
   int              junk_len;
   int              settings_used;
   logic [7:0]      text_q[$];

   radix_string_to_integer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] ch
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [31:0] value
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Guard against a hang anywhere in the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("run timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Sample both channels at the rising edge. Check the result first: a value
   // from this edge can never belong to a character accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_value(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
      end
   end

   // Receiver back-pressure; the pattern changes from phase to phase.
   always @(negedge clock) begin
      case (ready_mode)
         READY_ALWAYS: rsp_tready = 1'b1;
         READY_RANDOM: rsp_tready = ($urandom_range(0, 2) != 0);
         READY_PATTERN: begin
            ready_tick++;
            rsp_tready = (ready_tick % 7) < 4;
         end
         default: begin
            // Long stalls: now and then hold ready low for a random stretch set by stall_left.
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready = 1'b0;
            end else begin
               rsp_tready = 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
            end
         end
      endcase
   end

   // Send one character; open a new burst with a random gap when the old one is used up.
   task automatic send_char(input logic [7:0] c, input bit is_last);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            req_tdata  = 8'($urandom_range(0, 255));
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = is_last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_char(text_q[i], i == text_q.size() - 1);
      items_sent += text_q.size() - junk_len;
   endtask

   // Drop valid and hold off until every owed value has come back, then let
   // the result stage settle.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      burst_left = 0;
      while (sb.value_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup cycle then access cycle; registers sit on 8-byte strides.
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 5))
         0: return CH_TAB;
         1: return CH_LF;
         2: return CH_VT;
         3: return CH_FF;
         4: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   // Alphabet styles: distinct printable symbols, raw random bytes, or
   // printable symbols with a duplicate and a whitespace or sign symbol.
   function automatic logic [127:0] make_alphabet(int style);
      logic [127:0] a;
      logic [7:0]   c;
      bit           clash;
      int           k;
      a = '0;
      if (style == 1) begin
         for (k = 0; k < 4; k++) a[k*32 +: 32] = $urandom();
         return a;
      end
      for (k = 0; k < 16; k++) begin
         do begin
            c = 8'($urandom_range(33, 126));
            clash = (c == CH_PLUS || c == CH_MINUS);
            for (int j = 0; j < k; j++) if (a[j*8 +: 8] == c) clash = 1'b1;
         end while (clash);
         a[k*8 +: 8] = c;
      end
      if (style == 2) begin
         k = $urandom_range(1, 15);
         a[k*8 +: 8] = a[7:0];
         k = $urandom_range(1, 15);
         a[k*8 +: 8] = $urandom_range(0, 1) ? CH_SPACE : CH_MINUS;
         if ($urandom_range(0, 1)) begin
            k = $urandom_range(0, 15);
            a[k*8 +: 8] = CH_NUL;
         end
      end
      return a;
   endfunction

   task automatic program_alphabet(input logic [127:0] a);
      csr_write(REG_ALPHABET_LOW, a[63:0]);
      csr_write(REG_ALPHABET_HIGH, a[127:64]);
   endtask

   // Register settings per phase; the early ones cover the extremes.
   task automatic program_phase(input int p);
      case (p)
         1: begin
            csr_write(REG_ALPHABET_LOW, ALPHABET_LOW_RESET);
            csr_write(REG_ALPHABET_HIGH, 64'h4645_4443_4241_3938);   // "89ABCDEF"
            csr_write(REG_BASE_LEN, 64'd16);
         end
         2: csr_write(REG_BASE_LEN, 64'(MIN_BASE));
         3: begin
            program_alphabet(make_alphabet(0));
            csr_write(REG_BASE_LEN, 64'd0);                          // acts as base 2
         end
         4: begin
            program_alphabet(make_alphabet(1));
            csr_write(REG_BASE_LEN, 64'd31);                         // acts as base 16
         end
         5: begin
            program_alphabet(make_alphabet(2));
            csr_write(REG_BASE_LEN, 64'd17);
         end
         6: begin
            csr_write(REG_ALPHABET_LOW, '1);
            csr_write(REG_ALPHABET_HIGH, '0);
            csr_write(REG_BASE_LEN, 64'd1);
         end
         default: begin
            program_alphabet(make_alphabet($urandom_range(0, 2)));
            csr_write(REG_BASE_LEN, $urandom_range(0, 3) == 0 ?
                      64'($urandom_range(0, 31)) : 64'($urandom_range(2, 16)));
         end
      endcase
      settings_used++;
   endtask

   // Mostly well-formed numbers with random content; the rest is noise and
   // broken ones (whitespace after a sign stops the parse).
   task automatic make_text();
      int kind;
      int ndig;
      kind = $urandom_range(0, 9);
      text_q.delete();
      junk_len = 0;
      if (kind < 8) begin
         repeat ($urandom_range(0, 3)) text_q.push_back(pick_space());
         repeat ($urandom_range(0, 3)) text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
         // Long digit runs force the accumulator to wrap.
         ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         repeat (ndig) text_q.push_back(sb.symbol($urandom_range(0, sb.radix() - 1)));
         if ($urandom_range(0, 2) == 0) begin
            junk_len = $urandom_range(1, 3);
            repeat (junk_len) text_q.push_back(8'($urandom_range(0, 255)));
         end
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         text_q.push_back(CH_MINUS);
         text_q.push_back(pick_space());
         repeat ($urandom_range(1, 4))
            text_q.push_back(sb.symbol($urandom_range(0, sb.radix() - 1)));
      end
   endtask

   // Short directed strings in the reset base-10 setting.
   task automatic send_directed();
      junk_len = 0;
      // every whitespace kind, then a mixed sign run
      text_q = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_PLUS, CH_MINUS, 8'h39};
      send_text();
      // double minus, then a non-digit ends the parse before the final char
      text_q = '{CH_MINUS, CH_MINUS, 8'h35, 8'h61, 8'h33};
      send_text();
      // zero byte acts as a terminator
      text_q = '{CH_NUL, 8'h37};
      send_text();
      // no digits at all
      text_q = '{8'h78};
      send_text();
      text_q = '{8'hFF};
      send_text();
      text_q = '{CH_PLUS};
      send_text();
      text_q = '{CH_MINUS, 8'h30};
      send_text();
      text_q = '{8'h39};
      send_text();
   endtask

   initial begin
      sb            = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      ready_mode    = READY_ALWAYS;
      gaps_on       = 1'b1;
      burst_left    = 0;
      stall_left    = 0;
      ready_tick    = 0;
      cycle_count   = 0;
      items_sent    = 0;
      settings_used = 1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Change registers only with the block idle.
         if (p > 0) begin
            wait_drained();
            program_phase(p);
         end
         ready_mode = ready_mode_e'(p % 4);
         gaps_on    = (p % 3 != 1);
         if (p == 0) send_directed();
         while (items_sent < ITEM_TARGET * (p + 1) / NUM_PHASES) begin
            make_text();
            send_text();
            // Now and then pause until every owed value has come back.
            if ($urandom_range(0, 49) == 0) wait_drained();
         end
      end

      wait_drained();
      if (sb.value_q.size() != 0) sb.errors++;
      $display("covered %0d strings (%0d characters) over %0d register settings,",
               sb.strings_seen, sb.chars_seen, settings_used);
      $display("%0d parsed values checked, %0d mismatches", sb.values_seen, sb.errors);
      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
